@@ sv/rihsp_pkg.sv @@
`default_nettype none

package rihsp_pkg;

   // Address range of the image: sizes saturate at 2^ADDR_BITS bytes
   localparam int ADDR_BITS = 24;
   localparam int SIZE_W    = ADDR_BITS + 1;
   localparam int POS_W     = 24;
   localparam int CALC_W    = ADDR_BITS + 16;

   localparam logic [CALC_W-1:0] SIZE_CAP = CALC_W'(1) << ADDR_BITS;

   // Only header bytes 0..9 feed the decode
   localparam int HDR_KEEP  = 10;
   localparam int HDR_LEN   = 16;
   localparam int TRAINER_LEN = 512;

   localparam logic [4:0] PRG_SHIFT = 5'd14;   // 16 KiB units
   localparam logic [4:0] CHR_SHIFT = 5'd13;   // 8 KiB units

   localparam logic [7:0] MAGIC_0 = 8'h4E;
   localparam logic [7:0] MAGIC_1 = 8'h45;
   localparam logic [7:0] MAGIC_2 = 8'h53;
   localparam logic [7:0] MAGIC_3 = 8'h1A;

   localparam logic [3:0] NES2_MASK = 4'h0C;
   localparam logic [3:0] NES2_ID   = 4'h08;
   localparam logic [3:0] EXP_NIB   = 4'h0F;

   localparam logic [2:0] REG_HEADER  = 3'd0;
   localparam logic [2:0] REG_TRAINER = 3'd1;
   localparam logic [2:0] REG_PRG     = 3'd2;
   localparam logic [2:0] REG_CHR     = 3'd3;
   localparam logic [2:0] REG_EXCESS  = 3'd4;

   localparam logic [1:0] FMT_INVALID = 2'd0;
   localparam logic [1:0] FMT_INES    = 2'd1;
   localparam logic [1:0] FMT_NES2    = 2'd2;

   typedef logic [HDR_KEEP-1:0][7:0] hdr_bytes_type;

   typedef struct packed {
      logic [1:0]        fmt;
      logic [SIZE_W-1:0] prg_bytes;
      logic [SIZE_W-1:0] chr_bytes;
   } dec_type;

   typedef struct packed {
      logic [2:0]        region;
      logic [POS_W-1:0]  offset;
      logic [7:0]        data_out;
      logic              header_done;
      logic [1:0]        format;
      logic [SIZE_W-1:0] prg_bytes;
      logic [SIZE_W-1:0] chr_bytes;
      logic [11:0]       mapper;
      logic [3:0]        submapper;
      logic              trainer_present;
      logic [1:0]        console_type;
      logic              image_done;
   } rsp_type;

   // Size in bytes from a count nibble and low byte: units, or 2^E*(2M+1)
   function automatic logic [SIZE_W-1:0] calc_size(input logic [3:0] nib,
                                                   input logic [7:0] lo,
                                                   input logic [4:0] unit_sh,
                                                   input logic       nes2);
      logic [CALC_W-1:0] v;
      logic [5:0]        e;
      logic [2:0]        m;
      e = lo[7:2];
      m = {lo[1:0], 1'b1};
      if (!nes2) begin
         v = CALC_W'(lo) << unit_sh;
      end else if (nib == EXP_NIB) begin
         if (e >= 6'(ADDR_BITS)) begin
            v = SIZE_CAP;
         end else begin
            v = CALC_W'(m) << e;
         end
      end else begin
         v = CALC_W'({nib, lo}) << unit_sh;
      end
      if (v > SIZE_CAP) begin
         v = SIZE_CAP;
      end
      return v[SIZE_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ sv/rihsp_decode.sv @@
`default_nettype none

module rihsp_decode (
   input  wire rihsp_pkg::hdr_bytes_type hdr,
   output rihsp_pkg::dec_type            dec
);

   logic magic_ok;
   logic nes2;

   assign magic_ok = (hdr[0] == rihsp_pkg::MAGIC_0) && (hdr[1] == rihsp_pkg::MAGIC_1) &&
                     (hdr[2] == rihsp_pkg::MAGIC_2) && (hdr[3] == rihsp_pkg::MAGIC_3);
   assign nes2     = (hdr[7][3:0] & rihsp_pkg::NES2_MASK) == rihsp_pkg::NES2_ID;

   always_comb begin
      dec.fmt       = rihsp_pkg::FMT_INVALID;
      dec.prg_bytes = '0;
      dec.chr_bytes = '0;
      if (magic_ok) begin
         dec.fmt       = nes2 ? rihsp_pkg::FMT_NES2 : rihsp_pkg::FMT_INES;
         dec.prg_bytes = rihsp_pkg::calc_size(hdr[9][3:0], hdr[4],
                                              rihsp_pkg::PRG_SHIFT, nes2);
         dec.chr_bytes = rihsp_pkg::calc_size(hdr[9][7:4], hdr[5],
                                              rihsp_pkg::CHR_SHIFT, nes2);
      end
   end

endmodule

`default_nettype wire

@@ sv/rihsp_seq.sv @@
`default_nettype none

module rihsp_seq (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 fire,
   input  wire [7:0]           data_byte,
   input  wire                 restart,
   output rihsp_pkg::rsp_type  result
);

   logic [2:0]                   region_ff, region_in;
   logic [rihsp_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [1:0]                   fmt_ff, fmt_in;
   logic [rihsp_pkg::SIZE_W-1:0] prg_ff, prg_in;
   logic [rihsp_pkg::SIZE_W-1:0] chr_ff, chr_in;
   rihsp_pkg::hdr_bytes_type     hdr_ff;
   rihsp_pkg::dec_type           dec;

   logic [2:0]                   reg_cur;
   logic [rihsp_pkg::POS_W-1:0]  pos_cur;
   logic [1:0]                   fmt_cur;
   logic [rihsp_pkg::SIZE_W-1:0] prg_cur;
   logic [rihsp_pkg::SIZE_W-1:0] chr_cur;
   logic [rihsp_pkg::SIZE_W-1:0] pos_next_wide;
   logic                         ends;
   logic                         hdone;
   logic [2:0]                   reg_eff;
   logic [2:0]                   nxt;
   logic                         trainer;
   logic                         nes2;
   logic                         show;

   rihsp_decode u_decode (
      .hdr (hdr_ff),
      .dec (dec)
   );

   // Restart makes this word header byte 0 of a fresh image
   assign reg_cur = restart ? rihsp_pkg::REG_HEADER : region_ff;
   assign pos_cur = restart ? '0 : pos_ff;
   assign fmt_cur = restart ? rihsp_pkg::FMT_INVALID : fmt_ff;
   assign prg_cur = restart ? '0 : prg_ff;
   assign chr_cur = restart ? '0 : chr_ff;

   assign pos_next_wide = {1'b0, pos_cur} + rihsp_pkg::SIZE_W'(1);
   assign trainer       = hdr_ff[6][2];

   always_comb begin
      ends    = 1'b0;
      hdone   = 1'b0;
      reg_eff = reg_cur;
      case (reg_cur)
         rihsp_pkg::REG_HEADER: begin
            if (pos_cur >= rihsp_pkg::POS_W'(rihsp_pkg::HDR_LEN - 1)) begin
               ends  = 1'b1;
               hdone = 1'b1;
            end
         end
         rihsp_pkg::REG_TRAINER: begin
            ends = pos_cur >= rihsp_pkg::POS_W'(rihsp_pkg::TRAINER_LEN - 1);
         end
         rihsp_pkg::REG_PRG: begin
            ends = pos_next_wide >= prg_cur;
         end
         rihsp_pkg::REG_CHR: begin
            ends = pos_next_wide >= chr_cur;
         end
         default: begin
            reg_eff = rihsp_pkg::REG_EXCESS;
         end
      endcase
   end

   // Header end latches the decode, otherwise hold
   assign fmt_in = hdone ? dec.fmt : fmt_cur;
   assign prg_in = hdone ? dec.prg_bytes : prg_cur;
   assign chr_in = hdone ? dec.chr_bytes : chr_cur;

   // Skip empty regions
   always_comb begin
      if (fmt_in == rihsp_pkg::FMT_INVALID) begin
         nxt = rihsp_pkg::REG_EXCESS;
      end else if (reg_eff == rihsp_pkg::REG_HEADER && trainer) begin
         nxt = rihsp_pkg::REG_TRAINER;
      end else if (reg_eff <= rihsp_pkg::REG_TRAINER && prg_in != '0) begin
         nxt = rihsp_pkg::REG_PRG;
      end else if (reg_eff <= rihsp_pkg::REG_PRG && chr_in != '0) begin
         nxt = rihsp_pkg::REG_CHR;
      end else begin
         nxt = rihsp_pkg::REG_EXCESS;
      end
   end

   assign region_in = ends ? nxt : reg_eff;
   assign pos_in    = ends ? '0 : pos_next_wide[rihsp_pkg::POS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= rihsp_pkg::REG_HEADER;
         pos_ff    <= '0;
         fmt_ff    <= rihsp_pkg::FMT_INVALID;
         prg_ff    <= '0;
         chr_ff    <= '0;
      end else if (fire) begin
         region_ff <= region_in;
         pos_ff    <= pos_in;
         fmt_ff    <= fmt_in;
         prg_ff    <= prg_in;
         chr_ff    <= chr_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < rihsp_pkg::HDR_KEEP; i++) begin
         if (fire && reg_cur == rihsp_pkg::REG_HEADER && pos_cur[3:0] == 4'(i)) begin
            hdr_ff[i] <= data_byte;
         end
      end
   end

   assign nes2 = fmt_in == rihsp_pkg::FMT_NES2;
   assign show = (fmt_in != rihsp_pkg::FMT_INVALID) && (region_in != rihsp_pkg::REG_HEADER);

   always_comb begin
      result.region      = reg_eff;
      result.offset      = pos_cur;
      result.data_out    = data_byte;
      result.header_done = hdone;
      result.image_done  = ends && (fmt_in != rihsp_pkg::FMT_INVALID) &&
                           (nxt == rihsp_pkg::REG_EXCESS);
      result.format          = '0;
      result.prg_bytes       = '0;
      result.chr_bytes       = '0;
      result.mapper          = '0;
      result.submapper       = '0;
      result.trainer_present = 1'b0;
      result.console_type    = '0;
      if (show) begin
         result.format          = fmt_in;
         result.prg_bytes       = prg_in;
         result.chr_bytes       = chr_in;
         result.mapper          = {(nes2 ? hdr_ff[8][3:0] : 4'h0),
                                   hdr_ff[7][7:4], hdr_ff[6][7:4]};
         result.submapper       = nes2 ? hdr_ff[8][7:4] : 4'h0;
         result.trainer_present = trainer;
         result.console_type    = hdr_ff[7][1:0];
      end
   end

endmodule

`default_nettype wire

@@ sv/rom_image_header_stream_parser_unit.sv @@
`default_nettype none

// Cartridge image header parser. Feed the image one byte per word on req_;
// set req_tuser on the first byte of each image. Every byte gives one result
// word on rsp_ with its region tag (header, trainer, PRG, CHR, excess) and its
// offset in that region; from the sixteenth header byte on, the decoded
// format, PRG/CHR sizes (saturated at 16 MiB), mapper, submapper, trainer
// flag and console type ride along, and rsp_tlast marks the final data byte.
// One byte is taken every clock unless rsp_tready holds the output; a byte is
// registered in the input register, then its result word in the result register
// that drives rsp_. The rate is set by the single step of region counter compare
// and header decode between the input register and the result register.
module rom_image_header_stream_parser_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // [7:0] data_byte
   input  wire          req_tuser,   // [0] restart
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [103:0] rsp_tdata,   // offset, data_out, header_done, format,
                                     // prg_bytes, chr_bytes, mapper, submapper,
                                     // trainer_present, console_type
   output logic [2:0]   rsp_tuser,   // [2:0] region
   output logic         rsp_tlast    // image_done
);

   logic               s1_valid_ff, s1_valid_in;
   logic [7:0]         s1_data_ff;
   logic               s1_restart_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rihsp_pkg::rsp_type rsp_ff;
   rihsp_pkg::rsp_type result;
   logic               out_en;
   logic               s1_fire;

   assign out_en      = !rsp_valid_ff || rsp_tready;
   assign s1_fire     = s1_valid_ff && out_en;
   assign req_tready  = !s1_valid_ff || out_en;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = out_en ? s1_valid_ff : rsp_valid_ff;

   rihsp_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .fire      (s1_fire),
      .data_byte (s1_data_ff),
      .restart   (s1_restart_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_data_ff    <= req_tdata;
         s1_restart_ff <= req_tuser;
      end
      if (s1_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.region;
   assign rsp_tlast  = rsp_ff.image_done;
   assign rsp_tdata  = {rsp_ff.console_type, rsp_ff.trainer_present, rsp_ff.submapper,
                        rsp_ff.mapper, rsp_ff.chr_bytes, rsp_ff.prg_bytes,
                        rsp_ff.format, rsp_ff.header_done, rsp_ff.data_out,
                        rsp_ff.offset};

endmodule

`default_nettype wire
